### src/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

    localparam int LEN_BITS = 31;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;

    localparam logic [3:0] HDR_SIZE_SHORT = 4'd2;
    localparam logic [3:0] HDR_END_16     = 4'd4;
    localparam logic [3:0] HDR_END_64     = 4'd10;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_MASK = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                fin;
        logic [3:0]          opcode;
        logic [LEN_BITS-1:0] payload_length;
        logic [3:0]          header_size;
        logic [7:0]          payload_data;
        logic                last;
    } result_t;

endpackage

### src/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer.
//
// Input channel: one raw stream byte per transaction on data_byte
// (in_valid / in_ready). Output channel: at most one result per byte
// (out_valid / out_ready): a header result (kind 0) once the header and
// mask key are complete, one unmasked payload byte (kind 1) per payload
// byte, or a length error (kind 2) when a 64-bit length is 2^31 or more.
// last marks the final result of a frame; the next byte starts a new header.
// A result is registered: the accepted byte sits in the input register, then
// the parse logic loads the result register.
// Throughput: one byte per cycle while out_ready stays high.
// Bytes that produce no result (header bytes, mask key) still count against that rate.
// Reset clears both stages and returns the parser to expect byte zero of a
// header. When the receiver stalls, the result register holds, the input
// register takes one more byte, and in_ready then drops until out_ready.
module websocket_frame_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic                          fin,
    output logic [3:0]                    opcode,
    output logic [wsfd_pkg::LEN_BITS-1:0] payload_length,
    output logic [3:0]                    header_size,
    output logic [7:0]                    payload_data,
    output logic                          last
);

    logic              advance;
    logic              byte_valid;
    logic [7:0]        byte_data;
    wsfd_pkg::result_t res;

    assign advance = !out_valid || out_ready;

    wsfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (byte_valid && advance),
        .byte_data (byte_data),
        .advance   (advance),
        .res_valid (out_valid),
        .res       (res)
    );

    assign kind           = res.kind;
    assign fin            = res.fin;
    assign opcode         = res.opcode;
    assign payload_length = res.payload_length;
    assign header_size    = res.header_size;
    assign payload_data   = res.payload_data;
    assign last           = res.last;

endmodule

### src/wsfd_in_stage.sv
// Input register stage: holds one accepted byte until the parser takes it.
module wsfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

### src/wsfd_parser.sv
// Frame parser: header/length/mask state, payload unmasking and result register.
module wsfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_data,
    input  logic                advance,
    output logic                res_valid,
    output wsfd_pkg::result_t   res
);

    localparam int LB = wsfd_pkg::LEN_BITS;

    wsfd_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        hcount_reg, hcount_next;
    logic              fin_reg, fin_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              masked_reg, masked_next;
    logic [LB-1:0]     length_reg, length_next;
    logic [31:0]       key_reg, key_next;
    logic [LB-1:0]     remaining_reg, remaining_next;
    logic [1:0]        midx_reg, midx_next;
    logic              wide_reg, wide_next;
    logic              toolong_reg, toolong_next;

    logic              valid_reg;
    wsfd_pkg::result_t res_reg;

    logic              emit;
    wsfd_pkg::result_t res_next;

    logic [6:0]        len7;
    logic [3:0]        hcount_inc;
    logic [3:0]        ext_end;
    logic [LB-1:0]     len_shift;
    logic [LB-1:0]     rem_dec;
    logic [7:0]        mask_byte;

    assign len7       = byte_data[6:0];
    assign hcount_inc = hcount_reg + 4'd1;
    assign ext_end    = wide_reg ? wsfd_pkg::HDR_END_64 : wsfd_pkg::HDR_END_16;
    assign len_shift  = {length_reg[LB-9:0], byte_data};
    assign rem_dec    = remaining_reg - {{(LB-1){1'b0}}, 1'b1};
    assign mask_byte  = key_reg[{~midx_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        length_next    = length_reg;
        key_next       = key_reg;
        remaining_next = remaining_reg;
        midx_next      = midx_reg;
        wide_next      = wide_reg;
        toolong_next   = toolong_reg;
        emit           = 1'b0;
        res_next       = '0;

        unique case (phase_reg)
            wsfd_pkg::PH_HDR0:
            begin
                fin_next    = byte_data[7];
                opcode_next = byte_data[3:0];
                hcount_next = 4'd1;
                phase_next  = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1:
            begin
                masked_next  = byte_data[7];
                hcount_next  = wsfd_pkg::HDR_SIZE_SHORT;
                key_next     = '0;
                midx_next    = '0;
                toolong_next = 1'b0;
                if (len7 == wsfd_pkg::LEN7_EXT16 || len7 == wsfd_pkg::LEN7_EXT64)
                begin
                    length_next = '0;
                    wide_next   = (len7 == wsfd_pkg::LEN7_EXT64);
                    phase_next  = wsfd_pkg::PH_EXT;
                end
                else
                begin
                    length_next = {{(LB-7){1'b0}}, len7};
                    if (byte_data[7])
                    begin
                        phase_next = wsfd_pkg::PH_MASK;
                    end
                    else
                    begin
                        emit                    = 1'b1;
                        res_next.kind           = wsfd_pkg::KIND_HEADER;
                        res_next.payload_length = length_next;
                        res_next.header_size    = hcount_next;
                        res_next.last           = (len7 == 7'd0);
                        remaining_next          = length_next;
                        phase_next              = (len7 == 7'd0) ? wsfd_pkg::PH_HDR0
                                                                 : wsfd_pkg::PH_DATA;
                    end
                end
            end
            wsfd_pkg::PH_EXT:
            begin
                toolong_next = toolong_reg || (length_reg[LB-1 -: 8] != 8'd0);
                length_next  = len_shift;
                hcount_next  = hcount_inc;
                if (hcount_inc >= ext_end)
                begin
                    if (toolong_next)
                    begin
                        emit                 = 1'b1;
                        res_next.kind        = wsfd_pkg::KIND_LEN_ERR;
                        res_next.header_size = hcount_inc;
                        res_next.last        = 1'b1;
                        length_next          = '0;
                        phase_next           = wsfd_pkg::PH_HDR0;
                    end
                    else if (masked_reg)
                    begin
                        phase_next = wsfd_pkg::PH_MASK;
                    end
                    else
                    begin
                        emit                    = 1'b1;
                        res_next.kind           = wsfd_pkg::KIND_HEADER;
                        res_next.payload_length = len_shift;
                        res_next.header_size    = hcount_inc;
                        res_next.last           = (len_shift == '0);
                        remaining_next          = len_shift;
                        midx_next               = '0;
                        phase_next              = (len_shift == '0) ? wsfd_pkg::PH_HDR0
                                                                    : wsfd_pkg::PH_DATA;
                    end
                end
            end
            wsfd_pkg::PH_MASK:
            begin
                key_next    = {key_reg[23:0], byte_data};
                hcount_next = hcount_inc;
                midx_next   = midx_reg + 2'd1;
                if (midx_reg == 2'd3)
                begin
                    emit                    = 1'b1;
                    res_next.kind           = wsfd_pkg::KIND_HEADER;
                    res_next.payload_length = length_reg;
                    res_next.header_size    = hcount_inc;
                    res_next.last           = (length_reg == '0);
                    remaining_next          = length_reg;
                    midx_next               = '0;
                    phase_next              = (length_reg == '0) ? wsfd_pkg::PH_HDR0
                                                                 : wsfd_pkg::PH_DATA;
                end
            end
            wsfd_pkg::PH_DATA:
            begin
                midx_next               = midx_reg + 2'd1;
                remaining_next          = rem_dec;
                emit                    = 1'b1;
                res_next.kind           = wsfd_pkg::KIND_PAYLOAD;
                res_next.payload_length = length_reg;
                res_next.header_size    = hcount_reg;
                res_next.payload_data   = masked_reg ? (byte_data ^ mask_byte) : byte_data;
                res_next.last           = (rem_dec == '0);
                if (rem_dec == '0)
                begin
                    phase_next = wsfd_pkg::PH_HDR0;
                end
            end
            default:
            begin
                phase_next = wsfd_pkg::PH_HDR0;
            end
        endcase

        res_next.fin    = fin_next;
        res_next.opcode = opcode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsfd_pkg::PH_HDR0;
            hcount_reg    <= '0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            masked_reg    <= 1'b0;
            length_reg    <= '0;
            key_reg       <= '0;
            remaining_reg <= '0;
            midx_reg      <= '0;
            wide_reg      <= 1'b0;
            toolong_reg   <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg     <= phase_next;
                hcount_reg    <= hcount_next;
                fin_reg       <= fin_next;
                opcode_reg    <= opcode_next;
                masked_reg    <= masked_next;
                length_reg    <= length_next;
                key_reg       <= key_next;
                remaining_reg <= remaining_next;
                midx_reg      <= midx_next;
                wide_reg      <= wide_next;
                toolong_reg   <= toolong_next;
            end
            if (advance)
            begin
                valid_reg <= step && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

### dv/tb.sv
// Self-checking testbench for the WebSocket frame deframer top level.
`timescale 1ns / 1ps

module tb;
    import wsfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [30:0] payload_length;
    logic [3:0]  header_size;
    logic [7:0]  payload_data;
    logic        last;

    phase_t              st_phase     = PH_HDR0;
    logic [3:0]          hdr_cnt      = '0;
    logic                cur_fin      = 1'b0;
    logic [3:0]          cur_op       = '0;
    logic                cur_masked   = 1'b0;
    logic [LEN_BITS-1:0] cur_len      = '0;
    logic [31:0]         cur_key      = '0;
    logic [LEN_BITS-1:0] left         = '0;
    logic [1:0]          key_idx      = '0;
    logic                long_len     = 1'b0;
    logic                len_overflow = 1'b0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      sent_count     = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      hold_reqs      = 0;
    int      holds_done     = 0;
    int      hold_left      = 0;

    dir_row_t dir_rows [24] = '{
        '{8'h81, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_HEADER, 1'b1, 4'd1, 31'd0, 4'd2, 8'h00, 1'b1}},
        '{8'h8A, 1'b0, '0},
        '{8'h81, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_HEADER, 1'b1, 4'd10, 31'd1, 4'd6, 8'h00, 1'b0}},
        '{8'hAA, 1'b1, '{KIND_PAYLOAD, 1'b1, 4'd10, 31'd1, 4'd6, 8'h55, 1'b1}},
        '{8'h02, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_LEN_ERR, 1'b0, 4'd2, 31'd0, 4'd10, 8'h00, 1'b1}},
        '{8'h09, 1'b0, '0},
        '{8'h7E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b1, '{KIND_HEADER, 1'b0, 4'd9, 31'd1, 4'd4, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 1'b0, 4'd9, 31'd1, 4'd4, 8'hFF, 1'b1}}
    };

    websocket_frame_deframer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .fin            (fin),
        .opcode         (opcode),
        .payload_length (payload_length),
        .header_size    (header_size),
        .payload_data   (payload_data),
        .last           (last)
    );

    always #4 clk = ~clk;

    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        logic [6:0] len7;
        bit         got;
        bit         hdr_done;
        len7     = b[6:0];
        got      = 1'b0;
        hdr_done = 1'b0;
        r        = '0;
        r.fin    = cur_fin;
        r.opcode = cur_op;
        case (st_phase)
            PH_HDR0:
            begin
                cur_fin  = b[7];
                cur_op   = b[3:0];
                hdr_cnt  = 4'd1;
                st_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                cur_masked   = b[7];
                hdr_cnt      = HDR_SIZE_SHORT;
                cur_len      = '0;
                cur_key      = '0;
                key_idx      = '0;
                len_overflow = 1'b0;
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                begin
                    long_len = (len7 == LEN7_EXT64);
                    st_phase = PH_EXT;
                end
                else
                begin
                    cur_len = LEN_BITS'(len7);
                    if (cur_masked)
                        st_phase = PH_MASK;
                    else
                        hdr_done = 1'b1;
                end
            end
            PH_EXT:
            begin
                if (|cur_len[LEN_BITS-1:LEN_BITS-8])
                    len_overflow = 1'b1;
                cur_len = {cur_len[LEN_BITS-9:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt == (long_len ? HDR_END_64 : HDR_END_16))
                begin
                    if (len_overflow)
                    begin
                        r.kind        = KIND_LEN_ERR;
                        r.header_size = hdr_cnt;
                        r.last        = 1'b1;
                        cur_len       = '0;
                        st_phase      = PH_HDR0;
                        got           = 1'b1;
                    end
                    else if (cur_masked)
                        st_phase = PH_MASK;
                    else
                        hdr_done = 1'b1;
                end
            end
            PH_MASK:
            begin
                cur_key = {cur_key[23:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                key_idx = key_idx + 2'd1;
                if (key_idx == 2'd0)
                    hdr_done = 1'b1;
            end
            PH_DATA:
            begin
                r.kind           = KIND_PAYLOAD;
                r.payload_length = cur_len;
                r.header_size    = hdr_cnt;
                r.payload_data   = cur_masked ? (b ^ cur_key[31 - 8 * key_idx -: 8]) : b;
                key_idx          = key_idx + 2'd1;
                left             = left - 1'b1;
                r.last           = (left == '0);
                if (r.last)
                    st_phase = PH_HDR0;
                got = 1'b1;
            end
            default:
                st_phase = PH_HDR0;
        endcase
        if (hdr_done)
        begin
            r.kind           = KIND_HEADER;
            r.payload_length = cur_len;
            r.header_size    = hdr_cnt;
            r.last           = (cur_len == '0);
            left             = cur_len;
            key_idx          = '0;
            st_phase         = r.last ? PH_HDR0 : PH_DATA;
            got              = 1'b1;
        end
        return got;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = '0);
        result_t r;
        bit      got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        got = parse_byte(b, r);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else if (got)
            pending_results.insert(pending_results.size(), r);
        sent_count++;
    endtask

    task automatic wait_results_drained;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic send_frame(input logic [7:0] h0, input int width_sel,
                              input logic [63:0] len, input bit masked, input int n_payload);
        int i;
        send_byte(h0);
        case (width_sel)
            0:
                send_byte({masked, len[6:0]});
            1:
            begin
                send_byte({masked, LEN7_EXT16});
                for (i = 1; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
            default:
            begin
                send_byte({masked, LEN7_EXT64});
                for (i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked && len < 64'h8000_0000)
        begin
            for (i = 0; i < 4; i++)
                send_byte(8'($urandom));
        end
        for (i = 0; i < n_payload; i++)
            send_byte(8'($urandom));
    endtask

    task automatic send_random_frame;
        int          sel;
        int          p;
        logic [63:0] len;
        bit          masked;
        sel    = $urandom_range(99);
        masked = 1'($urandom_range(1));
        len    = 64'($urandom_range(12));
        if (sel < 55)
        begin
            if ($urandom_range(9) == 0)
                len = 64'($urandom_range(125));
            send_frame(8'($urandom), 0, len, masked, int'(len));
        end
        else if (sel < 75)
        begin
            len = 64'($urandom_range(24));
            send_frame(8'($urandom), 1, len, masked, int'(len));
        end
        else if (sel < 88)
            send_frame(8'($urandom), 2, len, masked, int'(len));
        else
        begin
            p   = $urandom_range(63, 31);
            len = {32'($urandom), 32'($urandom)};
            len = (len & ((64'd1 << p) - 64'd1)) | (64'd1 << p);
            send_frame(8'($urandom), 2, len, masked, 0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** websocket_frame_deframer_top: FAILED **");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0h data %0h", $time, kind,
                         payload_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("fin", 32'(want.fin), 32'(fin));
                check_field("opcode", 32'(want.opcode), 32'(opcode));
                check_field("payload_length", 32'(want.payload_length),
                            32'(payload_length));
                check_field("header_size", 32'(want.header_size), 32'(header_size));
                check_field("payload_data", 32'(want.payload_data), 32'(payload_data));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_reqs != holds_done)
        begin
            holds_done = hold_reqs;
            hold_left  = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 76;
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
        wait_results_drained();
        while (sent_count < 270)
            send_random_frame();

        wait_results_drained();
        send_idle_pct = 76;
        recv_idle_pct = 32;
        while (sent_count < 520)
            send_random_frame();

        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs <= hold_reqs + 1;
        while (sent_count < 620)
            send_random_frame();
        send_frame(8'($urandom), 1, 64'h0080, 1'b1, 128);
        send_frame(8'h82, 2, 64'h7FFF_FFFF, 1'b1, 3);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** websocket_frame_deframer_top: PASSED **");
        else
            $display("** websocket_frame_deframer_top: FAILED **");
        $finish;
    end

endmodule
